@@ rtl/rau_pkg.sv @@
package rau_pkg;

   localparam int WORD_BITS = 64;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;

   // Largest positive word and the magnitude of the most negative word.
   localparam word_type MAG_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type MIN_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_OVF = 2'd1;
   localparam logic [1:0] STATUS_DZ  = 2'd2;

   localparam logic [2:0] KIND_ADD  = 3'd0;
   localparam logic [2:0] KIND_SUB  = 3'd1;
   localparam logic [2:0] KIND_MUL  = 3'd2;
   localparam logic [2:0] KIND_DIV  = 3'd3;
   localparam logic [2:0] KIND_NEG  = 3'd4;
   localparam logic [2:0] KIND_INV  = 3'd5;
   localparam logic [2:0] KIND_MAKE = 3'd6;

   typedef enum logic [1:0] {
      UOP_DIV,
      UOP_MUL,
      UOP_GCD
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
      word_type    a;
      word_type    b;
   } unit_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } unit_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_A_GCD, S_A_DBD, S_A_DAD, S_A_MC1, S_A_MC2, S_A_SUM, S_A_END,
      S_M_G1, S_M_DAN, S_M_DBD, S_M_G2, S_M_DBN, S_M_DAD,
      S_M_MC1, S_M_MC2, S_M_END,
      S_MC_DIV, S_MC_MUL,
      S_R_CHK, S_R_GCD, S_R_DN, S_R_DD, S_R_FIN,
      S_DONE
   } state_type;

endpackage

@@ rtl/rau_unit.sv @@
// Shared multi-cycle unit: restoring division (one quotient bit per cycle),
// shift-and-add multiplication and binary gcd (one step per cycle).
module rau_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  rau_pkg::unit_req_type req,
   output rau_pkg::unit_rsp_type rsp
);

   localparam int W = rau_pkg::WORD_BITS;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   rau_pkg::unit_op_type    op_ff, op_in;
   rau_pkg::word_type       x_ff, x_in;
   rau_pkg::word_type       y_ff, y_in;
   logic [W:0]              rem_ff, rem_in;
   logic [rau_pkg::CNT_BITS-1:0] k_ff, k_in;
   logic [rau_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   rau_pkg::word_type       result_ff, result_in;

   logic [W:0] shifted;
   logic       qbit;

   always_comb begin
      shifted = {rem_ff[W-1:0], x_ff[W-1]};
      qbit    = (shifted >= {1'b0, y_ff});
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         x_in    = req.a;
         y_in    = req.b;
         rem_in  = '0;
         k_in    = '0;
         cnt_in  = rau_pkg::CNT_BITS'(W - 1);
      end else if (busy_ff) begin
         case (op_ff)
            rau_pkg::UOP_DIV: begin
               rem_in = qbit ? (shifted - {1'b0, y_ff}) : shifted;
               x_in   = {x_ff[W-2:0], qbit};
               if (cnt_ff == '0) begin
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
                  result_in = {x_ff[W-2:0], qbit};
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            rau_pkg::UOP_MUL: begin
               if (y_ff == '0) begin
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
                  result_in = rem_ff[W-1:0];
               end else begin
                  if (y_ff[0]) rem_in = {1'b0, rem_ff[W-1:0] + x_ff};
                  x_in = x_ff << 1;
                  y_in = y_ff >> 1;
               end
            end
            rau_pkg::UOP_GCD: begin
               if (x_ff == '0) begin
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
                  result_in = y_ff << k_ff;
               end else if (y_ff == '0) begin
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
                  result_in = x_ff << k_ff;
               end else if (!x_ff[0] && !y_ff[0]) begin
                  x_in = x_ff >> 1;
                  y_in = y_ff >> 1;
                  k_in = k_ff + 1'b1;
               end else if (!x_ff[0]) begin
                  x_in = x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_in = y_ff >> 1;
               end else if (x_ff >= y_ff) begin
                  x_in = x_ff - y_ff;
               end else begin
                  y_in = y_ff - x_ff;
               end
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff     <= op_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      rem_ff    <= rem_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Each gcd, each division and each checked multiplication runs on the single shared
// unit in rau_unit, all one after another, so the time a transaction takes is data
// dependent. Errors that are known from the operands alone go from idle straight to
// the done state.
// Throughput: one transaction at a time; the next is taken after the result leaves.
// Reset (synchronous, active high) returns to idle and drops any transaction.
module rational_arithmetic_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind[2:0], a_num[66:3], a_den[130:67], b_num[194:131], b_den[257:195], zero fill
   input  logic [263:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_num[63:0], res_den[126:64], status[128:127], zero fill
   output logic [135:0] rsp_tdata
);

   localparam int W = rau_pkg::WORD_BITS;

   // Operands are kept in sign and magnitude form; a magnitude of W bits holds
   // the most negative word as well.
   function automatic rau_pkg::word_type mag_of(input rau_pkg::word_type v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic signed [W+1:0] to_sgn(input logic neg,
                                                  input rau_pkg::word_type m);
      to_sgn = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
   endfunction

   rau_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic issued_ff, issued_in;
   logic div_ff, div_in;

   logic an_n_ff, an_n_in, ad_n_ff, ad_n_in, bn_n_ff, bn_n_in;
   rau_pkg::word_type an_m_ff, an_m_in, ad_m_ff, ad_m_in, bn_m_ff, bn_m_in;
   rau_pkg::word_type bd_m_ff, bd_m_in;
   rau_pkg::word_type g_ff, g_in, t1_ff, t1_in, t2_ff, t2_in;
   logic p1_n_ff, p1_n_in, mx_n_ff, mx_n_in, my_n_ff, my_n_in, mr_n_ff, mr_n_in;
   rau_pkg::word_type p1_m_ff, p1_m_in, mx_m_ff, mx_m_in, my_m_ff, my_m_in;
   rau_pkg::word_type mr_m_ff, mr_m_in;
   logic n_n_ff, n_n_in, d_n_ff, d_n_in;
   rau_pkg::word_type n_m_ff, n_m_in, d_m_ff, d_m_in;

   logic signed [W-1:0] res_num_ff;
   rau_pkg::word_type   res_den_ff;
   logic [1:0]          status_ff;

   rau_pkg::unit_req_type ureq;
   rau_pkg::unit_rsp_type ursp;

   rau_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (ureq),
      .rsp   (ursp)
   );

   // Input decode.
   logic [2:0]        kind;
   rau_pkg::word_type in_an, in_ad, in_bn, in_bd;
   logic              in_an_n, in_ad_n, in_bn_n;
   rau_pkg::word_type in_an_m, in_ad_m, in_bn_m;
   logic              accept;
   logic              early_err;
   logic [1:0]        early_st;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      kind    = req_tdata[2:0];
      in_an   = req_tdata[W+2:3];
      in_ad   = req_tdata[W+66:67];
      in_bn   = req_tdata[W+130:131];
      in_bd   = {1'b0, req_tdata[W+193:195]};
      in_an_n = in_an[W-1];
      in_ad_n = in_ad[W-1];
      in_bn_n = in_bn[W-1];
      in_an_m = mag_of(in_an);
      in_ad_m = mag_of(in_ad);
      in_bn_m = mag_of(in_bn);
   end

   // Errors that are known from the operands alone, in the order of priority.
   always_comb begin
      early_err = 1'b1;
      early_st  = rau_pkg::STATUS_OVF;
      if (kind <= rau_pkg::KIND_INV && (in_ad_n || in_ad_m == '0)) begin
         early_st = rau_pkg::STATUS_DZ;
      end else if (kind <= rau_pkg::KIND_DIV && in_bd == '0) begin
         early_st = rau_pkg::STATUS_DZ;
      end else begin
         case (kind)
            rau_pkg::KIND_ADD, rau_pkg::KIND_MUL, rau_pkg::KIND_MAKE:
               early_err = 1'b0;
            rau_pkg::KIND_SUB:
               early_err = in_bn_n && in_bn_m == rau_pkg::MIN_MAG;
            rau_pkg::KIND_DIV: begin
               if (in_bn_m == '0) early_st = rau_pkg::STATUS_DZ;
               else early_err = in_bn_n && in_bn_m == rau_pkg::MIN_MAG;
            end
            rau_pkg::KIND_NEG:
               early_err = in_an_n && in_an_m == rau_pkg::MIN_MAG;
            rau_pkg::KIND_INV: begin
               if (in_an_m == '0) early_st = rau_pkg::STATUS_DZ;
               else early_err = in_an_n && in_an_m == rau_pkg::MIN_MAG;
            end
            default: early_err = 1'b1;
         endcase
      end
   end

   // Checked multiply: the magnitude limit divided by one factor is compared
   // against the other factor before the product is formed.
   logic mc_zero, mc_ovf;
   assign mc_zero = (mx_m_ff == '0) || (my_m_ff == '0);
   assign mc_ovf  = mx_m_ff > ursp.result;

   // Numerator sum for add and sub.
   logic signed [W+1:0] sum;
   logic                sum_ovf;
   rau_pkg::word_type   sum_m;
   always_comb begin
      sum     = to_sgn(p1_n_ff, p1_m_ff) + to_sgn(mr_n_ff, mr_m_ff);
      sum_ovf = (sum > $signed({2'b00, rau_pkg::MAG_MAX}))
             || (sum < -$signed({2'b00, rau_pkg::MIN_MAG}));
      sum_m   = sum[W+1] ? W'(-sum) : W'(sum);
   end

   // Final range check of the reduced fraction.
   logic r_neg, r_ovf;
   always_comb begin
      r_neg = n_n_ff ^ d_n_ff;
      r_ovf = (d_m_ff > rau_pkg::MAG_MAX)
           || ({1'b0, n_m_ff} > ({1'b0, rau_pkg::MAG_MAX} + (W+1)'(r_neg)));
   end

   logic unit_state;
   always_comb begin
      case (state_ff)
         rau_pkg::S_A_GCD, rau_pkg::S_A_DBD, rau_pkg::S_A_DAD,
         rau_pkg::S_M_G1, rau_pkg::S_M_DAN, rau_pkg::S_M_DBD,
         rau_pkg::S_M_G2, rau_pkg::S_M_DBN, rau_pkg::S_M_DAD,
         rau_pkg::S_MC_MUL, rau_pkg::S_R_GCD, rau_pkg::S_R_DN, rau_pkg::S_R_DD:
            unit_state = 1'b1;
         rau_pkg::S_MC_DIV: unit_state = !mc_zero;
         default:           unit_state = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::S_IDLE: begin
            if (accept) begin
               if (early_err) state_in = rau_pkg::S_DONE;
               else if (kind == rau_pkg::KIND_ADD || kind == rau_pkg::KIND_SUB)
                  state_in = rau_pkg::S_A_GCD;
               else if (kind == rau_pkg::KIND_MUL) state_in = rau_pkg::S_M_G1;
               else state_in = rau_pkg::S_R_CHK;
            end
         end
         rau_pkg::S_A_GCD: if (ursp.done) state_in = rau_pkg::S_A_DBD;
         rau_pkg::S_A_DBD: if (ursp.done) state_in = rau_pkg::S_A_DAD;
         rau_pkg::S_A_DAD: if (ursp.done) state_in = rau_pkg::S_A_MC1;
         rau_pkg::S_A_MC1: state_in = rau_pkg::S_MC_DIV;
         rau_pkg::S_A_MC2: state_in = rau_pkg::S_MC_DIV;
         rau_pkg::S_A_SUM: state_in = sum_ovf ? rau_pkg::S_DONE : rau_pkg::S_MC_DIV;
         rau_pkg::S_A_END: state_in = rau_pkg::S_R_CHK;
         rau_pkg::S_M_G1:  if (ursp.done) state_in = rau_pkg::S_M_DAN;
         rau_pkg::S_M_DAN: if (ursp.done) state_in = rau_pkg::S_M_DBD;
         rau_pkg::S_M_DBD: if (ursp.done) state_in = rau_pkg::S_M_G2;
         rau_pkg::S_M_G2:  if (ursp.done) state_in = rau_pkg::S_M_DBN;
         rau_pkg::S_M_DBN: if (ursp.done) state_in = rau_pkg::S_M_DAD;
         rau_pkg::S_M_DAD: if (ursp.done) state_in = rau_pkg::S_M_MC1;
         rau_pkg::S_M_MC1: state_in = rau_pkg::S_MC_DIV;
         rau_pkg::S_M_MC2: state_in = rau_pkg::S_MC_DIV;
         rau_pkg::S_M_END: state_in = rau_pkg::S_R_CHK;
         rau_pkg::S_MC_DIV: begin
            if (mc_zero) state_in = ret_ff;
            else if (ursp.done) state_in = mc_ovf ? rau_pkg::S_DONE : rau_pkg::S_MC_MUL;
         end
         rau_pkg::S_MC_MUL: if (ursp.done) state_in = ret_ff;
         rau_pkg::S_R_CHK: begin
            if (d_m_ff == '0 || n_m_ff == '0) state_in = rau_pkg::S_DONE;
            else state_in = rau_pkg::S_R_GCD;
         end
         rau_pkg::S_R_GCD: if (ursp.done) state_in = rau_pkg::S_R_DN;
         rau_pkg::S_R_DN:  if (ursp.done) state_in = rau_pkg::S_R_DD;
         rau_pkg::S_R_DD:  if (ursp.done) state_in = rau_pkg::S_R_FIN;
         rau_pkg::S_R_FIN: begin
            if (!r_ovf && div_ff) state_in = rau_pkg::S_M_G1;
            else state_in = rau_pkg::S_DONE;
         end
         rau_pkg::S_DONE: if (rsp_tready) state_in = rau_pkg::S_IDLE;
         default: state_in = rau_pkg::S_IDLE;
      endcase
   end

   // Requests to the shared unit.
   always_comb begin
      ureq.op = rau_pkg::UOP_DIV;
      ureq.a  = '0;
      ureq.b  = '0;
      case (state_ff)
         rau_pkg::S_A_GCD: begin ureq.op = rau_pkg::UOP_GCD; ureq.a = ad_m_ff; ureq.b = bd_m_ff; end
         rau_pkg::S_A_DBD: begin ureq.a = bd_m_ff; ureq.b = g_ff; end
         rau_pkg::S_A_DAD: begin ureq.a = ad_m_ff; ureq.b = g_ff; end
         rau_pkg::S_M_G1:  begin ureq.op = rau_pkg::UOP_GCD; ureq.a = an_m_ff; ureq.b = bd_m_ff; end
         rau_pkg::S_M_DAN: begin ureq.a = an_m_ff; ureq.b = g_ff; end
         rau_pkg::S_M_DBD: begin ureq.a = bd_m_ff; ureq.b = g_ff; end
         rau_pkg::S_M_G2:  begin ureq.op = rau_pkg::UOP_GCD; ureq.a = bn_m_ff; ureq.b = ad_m_ff; end
         rau_pkg::S_M_DBN: begin ureq.a = bn_m_ff; ureq.b = g_ff; end
         rau_pkg::S_M_DAD: begin ureq.a = ad_m_ff; ureq.b = g_ff; end
         rau_pkg::S_MC_DIV: begin ureq.a = rau_pkg::MAG_MAX; ureq.b = my_m_ff; end
         rau_pkg::S_MC_MUL: begin ureq.op = rau_pkg::UOP_MUL; ureq.a = mx_m_ff; ureq.b = my_m_ff; end
         rau_pkg::S_R_GCD: begin ureq.op = rau_pkg::UOP_GCD; ureq.a = n_m_ff; ureq.b = d_m_ff; end
         rau_pkg::S_R_DN:  begin ureq.a = n_m_ff; ureq.b = g_ff; end
         rau_pkg::S_R_DD:  begin ureq.a = d_m_ff; ureq.b = g_ff; end
         default: ureq.op = rau_pkg::UOP_DIV;
      endcase
      ureq.start = unit_state && !issued_ff;
      issued_in  = ureq.start ? 1'b1 : (ursp.done ? 1'b0 : issued_ff);
   end

   // Result of the transaction, written as the sequencer finishes.
   logic                fin;
   logic [1:0]          fin_st;
   logic signed [W-1:0] fin_num;
   rau_pkg::word_type   fin_den;
   always_comb begin
      fin     = 1'b0;
      fin_st  = rau_pkg::STATUS_OVF;
      fin_num = '0;
      fin_den = '0;
      case (state_ff)
         rau_pkg::S_IDLE: begin
            fin    = accept && early_err;
            fin_st = early_st;
         end
         rau_pkg::S_A_SUM:  fin = sum_ovf;
         rau_pkg::S_MC_DIV: fin = !mc_zero && ursp.done && mc_ovf;
         rau_pkg::S_R_CHK: begin
            if (d_m_ff == '0) begin
               fin    = 1'b1;
               fin_st = rau_pkg::STATUS_DZ;
            end else if (n_m_ff == '0) begin
               fin     = 1'b1;
               fin_st  = rau_pkg::STATUS_OK;
               fin_den = rau_pkg::word_type'(1);
            end
         end
         rau_pkg::S_R_FIN: begin
            if (r_ovf) begin
               fin = 1'b1;
            end else if (!div_ff) begin
               fin     = 1'b1;
               fin_st  = rau_pkg::STATUS_OK;
               fin_num = r_neg ? -$signed(n_m_ff) : $signed(n_m_ff);
               fin_den = d_m_ff;
            end
         end
         default: fin = 1'b0;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      ret_in  = ret_ff;   div_in  = div_ff;
      an_n_in = an_n_ff;  an_m_in = an_m_ff;
      ad_n_in = ad_n_ff;  ad_m_in = ad_m_ff;
      bn_n_in = bn_n_ff;  bn_m_in = bn_m_ff;
      bd_m_in = bd_m_ff;
      g_in    = g_ff;     t1_in   = t1_ff;    t2_in   = t2_ff;
      p1_n_in = p1_n_ff;  p1_m_in = p1_m_ff;
      mx_n_in = mx_n_ff;  mx_m_in = mx_m_ff;
      my_n_in = my_n_ff;  my_m_in = my_m_ff;
      mr_n_in = mr_n_ff;  mr_m_in = mr_m_ff;
      n_n_in  = n_n_ff;   n_m_in  = n_m_ff;
      d_n_in  = d_n_ff;   d_m_in  = d_m_ff;
      case (state_ff)
         rau_pkg::S_IDLE: begin
            an_n_in = in_an_n;  an_m_in = in_an_m;
            ad_n_in = in_ad_n;  ad_m_in = in_ad_m;
            bn_n_in = (kind == rau_pkg::KIND_SUB) ? !in_bn_n : in_bn_n;
            bn_m_in = in_bn_m;
            bd_m_in = in_bd;
            div_in  = 1'b0;
            case (kind)
               rau_pkg::KIND_DIV: begin
                  // Reciprocal of b first; the sign moves to the numerator.
                  n_n_in = in_bn_n; n_m_in = in_bd;
                  d_n_in = 1'b0;    d_m_in = in_bn_m;
                  div_in = 1'b1;
               end
               rau_pkg::KIND_NEG: begin
                  n_n_in = !in_an_n; n_m_in = in_an_m;
                  d_n_in = in_ad_n;  d_m_in = in_ad_m;
               end
               rau_pkg::KIND_INV: begin
                  n_n_in = in_an_n; n_m_in = in_ad_m;
                  d_n_in = 1'b0;    d_m_in = in_an_m;
               end
               default: begin
                  n_n_in = in_an_n; n_m_in = in_an_m;
                  d_n_in = in_ad_n; d_m_in = in_ad_m;
               end
            endcase
         end
         rau_pkg::S_A_GCD: if (ursp.done) g_in = ursp.result;
         rau_pkg::S_A_DBD: if (ursp.done) t1_in = ursp.result;
         rau_pkg::S_A_DAD: if (ursp.done) t2_in = ursp.result;
         rau_pkg::S_A_MC1: begin
            mx_n_in = an_n_ff; mx_m_in = an_m_ff;
            my_n_in = 1'b0;    my_m_in = t1_ff;
            ret_in  = rau_pkg::S_A_MC2;
         end
         rau_pkg::S_A_MC2: begin
            p1_n_in = mr_n_ff; p1_m_in = mr_m_ff;
            mx_n_in = bn_n_ff; mx_m_in = bn_m_ff;
            my_n_in = 1'b0;    my_m_in = t2_ff;
            ret_in  = rau_pkg::S_A_SUM;
         end
         rau_pkg::S_A_SUM: begin
            n_n_in  = sum[W+1]; n_m_in = sum_m;
            mx_n_in = ad_n_ff;  mx_m_in = ad_m_ff;
            my_n_in = 1'b0;     my_m_in = t1_ff;
            ret_in  = rau_pkg::S_A_END;
         end
         rau_pkg::S_A_END: begin
            d_n_in = mr_n_ff; d_m_in = mr_m_ff;
         end
         rau_pkg::S_M_G1:  if (ursp.done) g_in = ursp.result;
         rau_pkg::S_M_DAN: if (ursp.done) an_m_in = ursp.result;
         rau_pkg::S_M_DBD: if (ursp.done) bd_m_in = ursp.result;
         rau_pkg::S_M_G2:  if (ursp.done) g_in = ursp.result;
         rau_pkg::S_M_DBN: if (ursp.done) bn_m_in = ursp.result;
         rau_pkg::S_M_DAD: if (ursp.done) ad_m_in = ursp.result;
         rau_pkg::S_M_MC1: begin
            mx_n_in = an_n_ff; mx_m_in = an_m_ff;
            my_n_in = bn_n_ff; my_m_in = bn_m_ff;
            ret_in  = rau_pkg::S_M_MC2;
         end
         rau_pkg::S_M_MC2: begin
            n_n_in  = mr_n_ff; n_m_in = mr_m_ff;
            mx_n_in = ad_n_ff; mx_m_in = ad_m_ff;
            my_n_in = 1'b0;    my_m_in = bd_m_ff;
            ret_in  = rau_pkg::S_M_END;
         end
         rau_pkg::S_M_END: begin
            d_n_in = mr_n_ff; d_m_in = mr_m_ff;
         end
         rau_pkg::S_MC_DIV: begin
            if (mc_zero) begin
               mr_n_in = 1'b0;
               mr_m_in = '0;
            end
         end
         rau_pkg::S_MC_MUL: begin
            if (ursp.done) begin
               mr_n_in = mx_n_ff ^ my_n_ff;
               mr_m_in = ursp.result;
            end
         end
         rau_pkg::S_R_GCD: if (ursp.done) g_in = ursp.result;
         rau_pkg::S_R_DN:  if (ursp.done) n_m_in = ursp.result;
         rau_pkg::S_R_DD:  if (ursp.done) d_m_in = ursp.result;
         rau_pkg::S_R_FIN: begin
            if (!r_ovf && div_ff) begin
               bn_n_in = r_neg;
               bn_m_in = n_m_ff;
               bd_m_in = d_m_ff;
               div_in  = 1'b0;
            end
         end
         default: div_in = div_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rau_pkg::S_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
      ret_ff  <= ret_in;   div_ff  <= div_in;
      an_n_ff <= an_n_in;  an_m_ff <= an_m_in;
      ad_n_ff <= ad_n_in;  ad_m_ff <= ad_m_in;
      bn_n_ff <= bn_n_in;  bn_m_ff <= bn_m_in;
      bd_m_ff <= bd_m_in;
      g_ff    <= g_in;     t1_ff   <= t1_in;    t2_ff   <= t2_in;
      p1_n_ff <= p1_n_in;  p1_m_ff <= p1_m_in;
      mx_n_ff <= mx_n_in;  mx_m_ff <= mx_m_in;
      my_n_ff <= my_n_in;  my_m_ff <= my_m_in;
      mr_n_ff <= mr_n_in;  mr_m_ff <= mr_m_in;
      n_n_ff  <= n_n_in;   n_m_ff  <= n_m_in;
      d_n_ff  <= d_n_in;   d_m_ff  <= d_m_in;
      if (fin) begin
         res_num_ff <= fin_num;
         res_den_ff <= fin_den;
         status_ff  <= fin_st;
      end
   end

   // The result waits in its output register until the consumer takes it.
   assign req_tready = (state_ff == rau_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == rau_pkg::S_DONE);
   assign rsp_tdata  = {7'b0, status_ff, 63'(res_den_ff), 64'(res_num_ff)};

endmodule

@@ rtl/rau_checker.sv @@
module rau_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [263:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata
);

   logic unused_req;
   assign unused_req = ^req_tdata;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request ready right after an accepted transaction");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[128:127] != 2'd3)
      else $error("undefined status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[128:127] != 2'd0 |->
         rsp_tdata[126:0] == 127'd0 && !unused_req == !unused_req)
      else $error("error result is not zero over zero");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/rational_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
   import rau_pkg::*;

   // Opcode 7 has no operation behind it and must come back as an overflow.
   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam longint WMAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint WMIN = -WMAX - 1;
   localparam longint unsigned WMAX_U = 64'h7fff_ffff_ffff_ffff;
   localparam int RANDOM_ITEMS = 1125;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      longint     num;
      logic [62:0] den;
      logic [1:0] st;
   } fraction_t;

   // One row of the directed table. When has_value is set the expected
   // fraction is written out in the row; otherwise the predictor supplies it.
   typedef struct {
      logic [2:0]  kind;
      longint      a_num;
      longint      a_den;
      longint      b_num;
      logic [62:0] b_den;
      bit          has_value;
      longint      e_num;
      logic [62:0] e_den;
      logic [1:0]  e_st;
   } op_row_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [263:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;

   fraction_t pending_results[$];
   int        error_count = 0;
   int        stall_cycles = 0;
   bit        no_idle = 0;

   rational_arithmetic_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor of the fraction arithmetic, written on 64-bit integers.
   // ---------------------------------------------------------------------
   function automatic longint unsigned magnitude(longint x);
      if (x < 0) return longint'(-(x + 1)) + 64'd1;
      return x;
   endfunction

   function automatic longint signed_from(longint unsigned m, bit neg);
      if (!neg) return longint'(m);
      if (m == 0) return 0;
      return -longint'(m - 64'd1) - 1;
   endfunction

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Returns 1 when the magnitude of the product exceeds the largest positive word.
   function automatic bit product_overflows(longint a, longint b, output longint p);
      longint unsigned ua, ub;
      p = 0;
      if (a == 0 || b == 0) return 0;
      ua = magnitude(a);
      ub = magnitude(b);
      if (ua > WMAX_U / ub) return 1;
      p = signed_from(ua * ub, (a < 0) != (b < 0));
      return 0;
   endfunction

   function automatic bit sum_overflows(longint a, longint b, output longint s);
      s = 0;
      if (b > 0 && a > WMAX - b) return 1;
      if (b < 0 && a < WMIN - b) return 1;
      s = a + b;
      return 0;
   endfunction

   function automatic logic [1:0] reduce_fraction(longint n, longint d,
                                                 output longint rn, output longint rd);
      longint unsigned un, ud, g;
      bit neg;
      rn = 0;
      rd = 0;
      if (d == 0) return STATUS_DZ;
      if (n == 0) begin
         rd = 1;
         return STATUS_OK;
      end
      un = magnitude(n);
      ud = magnitude(d);
      g = gcd_of(un, ud);
      un = un / g;
      ud = ud / g;
      neg = (n < 0) != (d < 0);
      if (ud > WMAX_U) return STATUS_OVF;
      if (un > WMAX_U + (neg ? 64'd1 : 64'd0)) return STATUS_OVF;
      rn = signed_from(un, neg);
      rd = longint'(ud);
      return STATUS_OK;
   endfunction

   function automatic logic [1:0] sum_fractions(longint an, longint ad, longint bn,
                                               longint bd, output longint rn,
                                               output longint rd);
      longint g, bdg, adg, p1, p2, n, d;
      rn = 0;
      rd = 0;
      g = longint'(gcd_of(ad, bd));
      bdg = bd / g;
      adg = ad / g;
      if (product_overflows(an, bdg, p1)) return STATUS_OVF;
      if (product_overflows(bn, adg, p2)) return STATUS_OVF;
      if (sum_overflows(p1, p2, n)) return STATUS_OVF;
      if (product_overflows(ad, bdg, d)) return STATUS_OVF;
      if (reduce_fraction(n, d, rn, rd) != STATUS_OK) return STATUS_OVF;
      return STATUS_OK;
   endfunction

   // Cross-cancels before multiplying so intermediate products stay small.
   function automatic logic [1:0] product_fractions(longint an, longint ad, longint bn,
                                                   longint bd, output longint rn,
                                                   output longint rd);
      longint g1, g2, n, d;
      rn = 0;
      rd = 0;
      g1 = longint'(gcd_of(magnitude(an), bd));
      g2 = longint'(gcd_of(magnitude(bn), ad));
      if (product_overflows(an / g1, bn / g2, n)) return STATUS_OVF;
      if (product_overflows(ad / g2, bd / g1, d)) return STATUS_OVF;
      if (reduce_fraction(n, d, rn, rd) != STATUS_OK) return STATUS_OVF;
      return STATUS_OK;
   endfunction

   function automatic logic [1:0] reciprocal(longint an, longint ad,
                                            output longint rn, output longint rd);
      rn = 0;
      rd = 0;
      if (an == 0) return STATUS_DZ;
      if (an > 0) return reduce_fraction(ad, an, rn, rd);
      if (an == WMIN) return STATUS_OVF;
      return reduce_fraction(-ad, -an, rn, rd);
   endfunction

   function automatic fraction_t compute_fraction(logic [2:0] kind, longint an,
                                                 longint ad, longint bn,
                                                 logic [62:0] bd_bits);
      fraction_t  r;
      longint     bd, rn, rd, tn, td;
      logic [1:0] st;
      bd = longint'({1'b0, bd_bits});
      rn = 0;
      rd = 0;
      if (kind <= KIND_INV && ad <= 0) st = STATUS_DZ;
      else if (kind <= KIND_DIV && bd == 0) st = STATUS_DZ;
      else case (kind)
         KIND_ADD: st = sum_fractions(an, ad, bn, bd, rn, rd);
         KIND_SUB: begin
            if (bn == WMIN) st = STATUS_OVF;
            else st = sum_fractions(an, ad, -bn, bd, rn, rd);
         end
         KIND_MUL: st = product_fractions(an, ad, bn, bd, rn, rd);
         KIND_DIV: begin
            st = reciprocal(bn, bd, tn, td);
            if (st == STATUS_OK) st = product_fractions(an, ad, tn, td, rn, rd);
         end
         KIND_NEG: begin
            if (an == WMIN) st = STATUS_OVF;
            else st = reduce_fraction(-an, ad, rn, rd);
         end
         KIND_INV: st = reciprocal(an, ad, rn, rd);
         KIND_MAKE: st = reduce_fraction(an, ad, rn, rd);
         default: st = STATUS_OVF;
      endcase
      if (st != STATUS_OK) begin
         rn = 0;
         rd = 0;
      end
      r.num = rn;
      r.den = rd[62:0];
      r.st = st;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Random operand sources.
   // ---------------------------------------------------------------------
   function automatic longint pick_extreme();
      case ($urandom_range(0, 5))
         0: return WMIN;
         1: return WMAX;
         2: return 0;
         3: return 1;
         4: return -1;
         default: return WMIN + 1;
      endcase
   endfunction

   function automatic longint random_numerator();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return longint'($urandom_range(0, 2000)) - 1000;
         5, 6: return longint'(w);
         7: return longint'(int'(w[31:0]));
         default: return pick_extreme();
      endcase
   endfunction

   // Mostly canonical positive denominators; occasionally anything at all.
   function automatic longint random_denominator();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: return longint'($urandom_range(1, 1000));
         11, 12, 13: return (w[62:0] == 0) ? 1 : longint'({1'b0, w[62:0]});
         14: return longint'($urandom_range(1, 65535));
         15: return WMAX;
         16: return 1;
         17: return longint'(w);
         18: return 0;
         default: return -longint'($urandom_range(1, 1000));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents one transaction and holds it until it is taken.
   // ---------------------------------------------------------------------
   task automatic send_operation(logic [2:0] kind, longint an, longint ad, longint bn,
                                 logic [62:0] bd, fraction_t expected);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 37) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {6'b0, bd, bn, ad, an, kind};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(expected);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // The receiver stalls at random except during the steady stretch.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle || ($urandom_range(0, 99) >= 37);
   end

   // Monitor: compares each returned fraction against the oldest expectation.
   always @(posedge clock) begin
      fraction_t want;
      longint    got_num;
      logic [62:0] got_den;
      logic [1:0] got_st;
      got_num = rsp_tdata[63:0];
      got_den = rsp_tdata[126:64];
      got_st = rsp_tdata[128:127];
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %0d/%0d status %0d", $time,
                     got_num, got_den, got_st);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got_num !== want.num) begin
               $display("%0t: numerator expected %0d actual %0d", $time, want.num, got_num);
               error_count++;
            end
            if (got_den !== want.den) begin
               $display("%0t: denominator expected %0d actual %0d", $time, want.den,
                        got_den);
               error_count++;
            end
            if (got_st !== want.st) begin
               $display("%0t: status expected %0d actual %0d", $time, want.st, got_st);
               error_count++;
            end
         end
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: a directed table, then random transactions.
   // ---------------------------------------------------------------------
   op_row_t directed[$] = '{
      '{KIND_ADD,  1, 2, 1, 3, 0, 0, 0, STATUS_OK},
      '{KIND_ADD,  WMAX, 1, 1, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_ADD,  WMIN, WMAX, WMAX, 1, 0, 0, 0, STATUS_OK},
      '{KIND_ADD,  1, 0, 1, 1, 1, 0, 0, STATUS_DZ},
      '{KIND_SUB,  0, 1, 0, 1, 1, 0, 1, STATUS_OK},
      '{KIND_SUB,  5, 1, WMIN, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_SUB,  -7, 12, 5, 18, 0, 0, 0, STATUS_OK},
      '{KIND_MUL,  2, 3, 3, 4, 0, 0, 0, STATUS_OK},
      '{KIND_MUL,  WMAX, 1, WMAX, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_MUL,  WMIN, 1, 1, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_MUL,  3, 4, 1, 0, 1, 0, 0, STATUS_DZ},
      '{KIND_DIV,  1, 2, 0, 1, 1, 0, 0, STATUS_DZ},
      '{KIND_DIV,  3, 4, -5, 7, 0, 0, 0, STATUS_OK},
      '{KIND_NEG,  WMIN, 1, 0, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_NEG,  5, 10, 0, 1, 0, 0, 0, STATUS_OK},
      '{KIND_INV,  0, 1, 0, 1, 1, 0, 0, STATUS_DZ},
      '{KIND_INV,  WMIN, 1, 0, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_INV,  -3, 6, 0, 1, 0, 0, 0, STATUS_OK},
      '{KIND_MAKE, 6, 0, 0, 1, 1, 0, 0, STATUS_DZ},
      '{KIND_MAKE, WMIN, -1, 0, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_MAKE, 1, WMIN, 0, 1, 1, 0, 0, STATUS_OVF},
      '{KIND_MAKE, 0, -5, 0, 1, 1, 0, 1, STATUS_OK},
      '{KIND_MAKE, WMAX, WMAX, 0, 1, 1, 1, 1, STATUS_OK},
      '{KIND_MAKE, -12, -18, 0, 1, 0, 0, 0, STATUS_OK},
      '{KIND_UNUSED, 1, 1, 1, 1, 1, 0, 0, STATUS_OVF}
   };

   initial begin
      fraction_t   expected;
      logic [2:0]  kind;
      longint      an, ad, bn;
      logic [62:0] bd;
      int          quiet_start;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].has_value) begin
            expected.num = directed[i].e_num;
            expected.den = directed[i].e_den;
            expected.st = directed[i].e_st;
         end else begin
            expected = compute_fraction(directed[i].kind, directed[i].a_num,
                                        directed[i].a_den, directed[i].b_num,
                                        directed[i].b_den);
         end
         send_operation(directed[i].kind, directed[i].a_num, directed[i].a_den,
                        directed[i].b_num, directed[i].b_den, expected);
      end

      // A stretch of 150 transactions runs with neither side idling.
      quiet_start = $urandom_range(200, 700);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= quiet_start) && (n < quiet_start + 150);
         kind = ($urandom_range(0, 49) == 0) ? KIND_UNUSED : 3'($urandom_range(0, 6));
         an = random_numerator();
         ad = random_denominator();
         bn = random_numerator();
         bd = 63'(random_denominator());
         if (kind == KIND_MAKE && $urandom_range(0, 2) == 0) ad = random_numerator();
         expected = compute_fraction(kind, an, ad, bn, bd);
         send_operation(kind, an, ad, bn, bd, expected);
      end
      no_idle = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rau_pkg.sv
rtl/rau_unit.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
tb/rational_arithmetic_unit_tb.sv
